// ----- hw/rtl/radar_measurement_jacobian_assert.svh -----
// ---------------------------------------------------------------------------
// Radar measurement Jacobian assertion macros
// Immediate-reset-aware concurrent checks, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RMJ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rmj check failed");
// next-cycle implication
`define RMJ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rmj check failed");
`else
`define RMJ_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define RMJ_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hw/rtl/rmj_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmj_pkg
// Shared types and constants of the radar measurement Jacobian.
// ---------------------------------------------------------------------------
package rmj_pkg;

    localparam int DATA_W      = 32;
    localparam int RES_W       = 48;
    localparam int QBITS       = 48;
    localparam int MIN_W       = 16;
    localparam int SQRT_STAGES = 32;
    // divider: overflow check, one stage per quotient bit, saturation
    localparam int DIV_LAT     = QBITS + 2;
    localparam int PIPE_LAT    = 3 + SQRT_STAGES + 2 + DIV_LAT;

    localparam logic [MIN_W-1:0] MIN_R2_RESET = 16'd7;
    localparam logic [RES_W-1:0] POS_LIMIT    = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] NEG_LIMIT    = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } in_word_t;

    typedef struct packed {
        logic signed [RES_W-1:0] drange_dpx;
        logic signed [RES_W-1:0] drange_dpy;
        logic signed [RES_W-1:0] dbearing_dpx;
        logic signed [RES_W-1:0] dbearing_dpy;
        logic signed [RES_W-1:0] drate_dpx;
        logic signed [RES_W-1:0] drate_dpy;
        logic                    range_clamped;
    } out_word_t;

endpackage

// ----- hw/rtl/rmj_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider: one quotient bit per stage, truncated,
// signed and saturated to 48 bits.
// ---------------------------------------------------------------------------
module rmj_div
    import rmj_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  logic                neg,
    output logic [RES_W-1:0]    res
);

    localparam int HIW = NW - QBITS;
    localparam int HW  = (HIW > DW) ? HIW : DW;

    logic [DW-1:0]    rem_reg [0:QBITS];
    logic [QBITS-1:0] low_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic [DW-1:0]    den_reg [0:QBITS];
    logic             neg_reg [0:QBITS];
    logic             ovf_reg [0:QBITS];
    logic [RES_W-1:0] res_reg;

    logic [HW-1:0]    hi_ext;
    logic [HW-1:0]    den_ext;

    assign hi_ext  = HW'(num[NW-1:QBITS]);
    assign den_ext = HW'(den);

    // entry: quotient of 2^48 or more means saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (hi_ext >= den_ext);
            rem_reg[0] <= hi_ext[DW-1:0];
            low_reg[0] <= num[QBITS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QBITS-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k+1] <= {low_reg[k][QBITS-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QBITS-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // saturate and apply sign
    logic [RES_W-1:0] lim;
    logic [RES_W-1:0] mag;
    logic [RES_W-1:0] res_next;

    always_comb
    begin
        lim      = neg_reg[QBITS] ? NEG_LIMIT : POS_LIMIT;
        mag      = (ovf_reg[QBITS] || (q_reg[QBITS] > lim)) ? lim : q_reg[QBITS];
        res_next = neg_reg[QBITS] ? (~mag + 1'b1) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/radar_measurement_jacobian.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle while the skid register is empty; the
// 32-stage square root and the six 50-stage dividers are fully pipelined.
// A one-word skid register holds a result that is not taken.
// Reset (rst_n, async, low) empties the pipeline and sets min_range_squared to 7.
// ---------------------------------------------------------------------------
// radar_measurement_jacobian
// Position-derivative entries of the 3x4 radar measurement Jacobian of a CV state.
// ---------------------------------------------------------------------------
module radar_measurement_jacobian
    import rmj_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MIN_W-1:0] cfg_data
);

`include "radar_measurement_jacobian_assert.svh"

    typedef struct packed {
        logic [31:0] apx;
        logic [31:0] apy;
        logic        px_neg;
        logic        py_neg;
        logic        py_pos;
        logic [63:0] r2;
        logic [63:0] cmag;
        logic        cneg;
        logic        clamped;
    } side_t;

    logic              en;
    logic [MIN_W-1:0]  min_r2_reg;
    logic              valid_reg [0:PIPE_LAT-1];
    logic              hold_valid_reg;
    out_word_t         hold_reg;
    out_word_t         last_word;

    // pipeline moves unless the skid register is occupied
    assign en        = !hold_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_r2_reg <= MIN_R2_RESET;
        end
        else if (cfg_valid)
        begin
            min_r2_reg <= cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // stage 1: magnitudes and products
    logic [31:0] apx1_reg, apy1_reg;
    logic        pxn1_reg, pyn1_reg, pyp1_reg;
    logic [63:0] sqx1_reg, sqy1_reg;
    logic signed [63:0] a1_reg, b1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            apx1_reg <= in_data.pos_x[31] ? (~in_data.pos_x + 1'b1) : in_data.pos_x;
            apy1_reg <= in_data.pos_y[31] ? (~in_data.pos_y + 1'b1) : in_data.pos_y;
            pxn1_reg <= in_data.pos_x[31];
            pyn1_reg <= in_data.pos_y[31];
            pyp1_reg <= !in_data.pos_y[31] && (in_data.pos_y != '0);
            sqx1_reg <= 64'(in_data.pos_x) * 64'(in_data.pos_x);
            sqy1_reg <= 64'(in_data.pos_y) * 64'(in_data.pos_y);
            a1_reg   <= 64'(in_data.vel_x) * 64'(in_data.pos_y);
            b1_reg   <= 64'(in_data.vel_y) * 64'(in_data.pos_x);
        end
    end

    // stage 2: squared range and cross term
    side_t s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg.apx     <= apx1_reg;
            s2_reg.apy     <= apy1_reg;
            s2_reg.px_neg  <= pxn1_reg;
            s2_reg.py_neg  <= pyn1_reg;
            s2_reg.py_pos  <= pyp1_reg;
            s2_reg.r2      <= sqx1_reg + sqy1_reg;
            s2_reg.cneg    <= (a1_reg < b1_reg);
            s2_reg.cmag    <= (a1_reg >= b1_reg) ? 64'(a1_reg - b1_reg)
                                                 : 64'(b1_reg - a1_reg);
            s2_reg.clamped <= 1'b0;
        end
    end

    // stage 3: clamp to the minimum (zero acts as one)
    logic [MIN_W-1:0] eff_min;
    logic [63:0]      min_q;
    side_t            side_next;
    side_t            side_reg [0:SQRT_STAGES];
    logic [63:0]      sq_v_reg [0:SQRT_STAGES];
    logic [63:0]      sq_r_reg [0:SQRT_STAGES];

    assign eff_min = (min_r2_reg == '0) ? MIN_W'(1) : min_r2_reg;
    assign min_q   = {32'd0, eff_min, 16'd0};

    always_comb
    begin
        side_next         = s2_reg;
        side_next.r2      = (s2_reg.r2 < min_q) ? min_q : s2_reg.r2;
        side_next.clamped = (s2_reg.r2 < min_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            sq_v_reg[0] <= side_next.r2;
            sq_r_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        logic        take;

        assign trial = sq_r_reg[i] + BIT;
        assign take  = (sq_v_reg[i] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                sq_v_reg[i+1] <= take ? (sq_v_reg[i] - trial) : sq_v_reg[i];
                sq_r_reg[i+1] <= take ? ((sq_r_reg[i] >> 1) + BIT) : (sq_r_reg[i] >> 1);
            end
        end
    end

    // multiply 1: 32x32 partial products
    side_t       sm_reg;
    logic [31:0] rho_m_reg;
    logic [63:0] den_lo_reg, den_hi_reg;
    logic [63:0] ny_lo_reg, ny_hi_reg, nx_lo_reg, nx_hi_reg;
    logic [31:0] rho;

    assign rho = sq_r_reg[SQRT_STAGES][31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_reg     <= side_reg[SQRT_STAGES];
            rho_m_reg  <= rho;
            den_lo_reg <= 64'(side_reg[SQRT_STAGES].r2[31:0]) * 64'(rho);
            den_hi_reg <= 64'(side_reg[SQRT_STAGES].r2[63:32]) * 64'(rho);
            ny_lo_reg  <= 64'(side_reg[SQRT_STAGES].apy) * 64'(side_reg[SQRT_STAGES].cmag[31:0]);
            ny_hi_reg  <= 64'(side_reg[SQRT_STAGES].apy) * 64'(side_reg[SQRT_STAGES].cmag[63:32]);
            nx_lo_reg  <= 64'(side_reg[SQRT_STAGES].apx) * 64'(side_reg[SQRT_STAGES].cmag[31:0]);
            nx_hi_reg  <= 64'(side_reg[SQRT_STAGES].apx) * 64'(side_reg[SQRT_STAGES].cmag[63:32]);
        end
    end

    // multiply 2: sum partials, form dividends and divisors
    logic [63:0]  n0_reg, n1_reg, n2_reg, n3_reg;
    logic [31:0]  rho_d_reg;
    logic [63:0]  r2_d_reg;
    logic [95:0]  den3_reg;
    logic [111:0] n4_reg, n5_reg;
    logic         sg0_reg, sg1_reg, sg2_reg, sg3_reg, sg4_reg, sg5_reg;
    logic         clamp_m_reg;
    logic         cnz;
    logic [95:0]  ny_sum, nx_sum;

    assign cnz    = (sm_reg.cmag != '0);
    assign ny_sum = 96'(ny_lo_reg) + {ny_hi_reg, 32'd0};
    assign nx_sum = 96'(nx_lo_reg) + {nx_hi_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg      <= {16'd0, sm_reg.apx, 16'd0};
            n1_reg      <= {16'd0, sm_reg.apy, 16'd0};
            n2_reg      <= {sm_reg.apy, 32'd0};
            n3_reg      <= {sm_reg.apx, 32'd0};
            n4_reg      <= {ny_sum, 16'd0};
            n5_reg      <= {nx_sum, 16'd0};
            rho_d_reg   <= rho_m_reg;
            r2_d_reg    <= sm_reg.r2;
            den3_reg    <= 96'(den_lo_reg) + {den_hi_reg, 32'd0};
            sg0_reg     <= sm_reg.px_neg;
            sg1_reg     <= sm_reg.py_neg;
            sg2_reg     <= sm_reg.py_pos;
            sg3_reg     <= sm_reg.px_neg;
            sg4_reg     <= cnz && (sm_reg.py_neg != sm_reg.cneg);
            sg5_reg     <= cnz && (sm_reg.px_neg == sm_reg.cneg);
            clamp_m_reg <= sm_reg.clamped;
        end
    end

    // six dividers
    logic [RES_W-1:0] q0, q1, q2, q3, q4, q5;

    rmj_div #(.NW(64), .DW(32)) u_div0 (.clk(clk), .en(en), .num(n0_reg),
        .den(rho_d_reg), .neg(sg0_reg), .res(q0));
    rmj_div #(.NW(64), .DW(32)) u_div1 (.clk(clk), .en(en), .num(n1_reg),
        .den(rho_d_reg), .neg(sg1_reg), .res(q1));
    rmj_div #(.NW(64), .DW(64)) u_div2 (.clk(clk), .en(en), .num(n2_reg),
        .den(r2_d_reg), .neg(sg2_reg), .res(q2));
    rmj_div #(.NW(64), .DW(64)) u_div3 (.clk(clk), .en(en), .num(n3_reg),
        .den(r2_d_reg), .neg(sg3_reg), .res(q3));
    rmj_div #(.NW(112), .DW(96)) u_div4 (.clk(clk), .en(en), .num(n4_reg),
        .den(den3_reg), .neg(sg4_reg), .res(q4));
    rmj_div #(.NW(112), .DW(96)) u_div5 (.clk(clk), .en(en), .num(n5_reg),
        .den(den3_reg), .neg(sg5_reg), .res(q5));

    // clamp flag rides alongside the dividers
    logic clamp_pipe_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_pipe_reg[0] <= clamp_m_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                clamp_pipe_reg[i] <= clamp_pipe_reg[i-1];
            end
        end
    end

    always_comb
    begin
        last_word.drange_dpx    = q0;
        last_word.drange_dpy    = q1;
        last_word.dbearing_dpx  = q2;
        last_word.dbearing_dpy  = q3;
        last_word.drate_dpx     = q4;
        last_word.drate_dpy     = q5;
        last_word.range_clamped = clamp_pipe_reg[DIV_LAT-1];
    end

    // output skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (hold_valid_reg)
        begin
            if (out_ready)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
        else if (valid_reg[PIPE_LAT-1] && !out_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_valid_reg)
        begin
            hold_reg <= last_word;
        end
    end

    assign out_valid = hold_valid_reg || valid_reg[PIPE_LAT-1];
    assign out_data  = hold_valid_reg ? hold_reg : last_word;

    // checks
    `RMJ_ASSERT_NOW(a_rho_nonzero, clk, rst_n, valid_reg[2+SQRT_STAGES], rho != '0)
    `RMJ_ASSERT_NEXT(a_stall_freezes, clk, rst_n, hold_valid_reg && !out_ready,
        hold_valid_reg && $stable(hold_reg))
    `RMJ_ASSERT_NEXT(a_hold_frees, clk, rst_n, hold_valid_reg && out_ready, !hold_valid_reg)

endmodule
